### sv/crc16_frame_builder_macros.svh
// Assertion macros for the file that checks its own logic.
// Each macro expects clk_i and rst_ni in scope.
`ifndef CRC16_FRAME_BUILDER_MACROS_SVH
`define CRC16_FRAME_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cfb_pkg.sv
`default_nettype none

package cfb_pkg;

  // CRC-16/CCITT-FALSE constants.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  // Frame delimiter byte.
  localparam logic [7:0] FrameDelim = 8'h7E;

  // Register reset values.
  localparam logic [15:0] LenReset  = 16'h0000;
  localparam logic [15:0] DestReset = 16'h5678;
  localparam logic [15:0] SrcReset  = 16'h1234;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgIdxLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxDest   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxSrc    = 2'd2;

  // Input item.
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       last_of_run;
  } out_item_t;

  // Configuration write transaction.
  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [15:0]        data;
  } cfg_wr_t;

  // Command passed from the classifier to the byte sequencer.
  typedef struct packed {
    logic        is_start;
    logic        close;
    logic [7:0]  data_byte;
    logic [15:0] dest;
    logic [15:0] src;
    logic [15:0] len;
  } cmd_t;

  // Sequencer position, one-hot.
  typedef enum logic [9:0] {
    PosDelim  = 10'b00_0000_0001,
    PosDestHi = 10'b00_0000_0010,
    PosDestLo = 10'b00_0000_0100,
    PosSrcHi  = 10'b00_0000_1000,
    PosSrcLo  = 10'b00_0001_0000,
    PosLenHi  = 10'b00_0010_0000,
    PosLenLo  = 10'b00_0100_0000,
    PosData   = 10'b00_1000_0000,
    PosCrcHi  = 10'b01_0000_0000,
    PosCrcLo  = 10'b10_0000_0000
  } pos_e;

  // Bytewise CRC update, MSB first.
  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/cfb_fifo.sv
`default_nettype none

module cfb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### sv/cfb_front.sv
`default_nettype none

module cfb_front
  import cfb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_wr_t  cfg_i,
  input  wire logic     push_i,
  input  wire in_item_t in_data_i,
  input  wire logic     cmd_full_i,
  output logic          cmd_push_o,
  output cmd_t          cmd_o
);

  logic [15:0] len_q, dest_q, src_q;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic        in_frame_q, in_frame_d;
  logic        accept;

  assign accept = push_i && !cmd_full_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenReset;
      dest_q <= DestReset;
      src_q  <= SrcReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgIdxLength: len_q  <= cfg_i.data;
        CfgIdxDest:   dest_q <= cfg_i.data;
        CfgIdxSrc:    src_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Classify the accepted transaction and track the open frame.
  always_comb begin
    in_frame_d     = in_frame_q;
    bytes_left_d   = bytes_left_q;
    cmd_push_o     = 1'b0;
    cmd_o.is_start = !in_data_i.mode;
    cmd_o.data_byte = in_data_i.data_byte;
    cmd_o.dest     = dest_q;
    cmd_o.src      = src_q;
    cmd_o.len      = len_q;
    cmd_o.close    = 1'b0;
    if (accept) begin
      if (!in_data_i.mode) begin
        // A start abandons any open frame.
        cmd_push_o   = 1'b1;
        cmd_o.close  = (len_q == 16'h0000);
        in_frame_d   = (len_q != 16'h0000);
        bytes_left_d = len_q;
      end else if (in_frame_q) begin
        cmd_push_o   = 1'b1;
        cmd_o.close  = (bytes_left_q == 16'h0001);
        bytes_left_d = bytes_left_q - 16'h0001;
        if (bytes_left_q == 16'h0001) begin
          in_frame_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

`default_nettype wire

### sv/cfb_back.sv
`default_nettype none

module cfb_back
  import cfb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_empty_i,
  output logic      cmd_pop_o,
  input  wire logic out_full_i,
  output logic      out_push_o,
  output out_item_t out_item_o
);

  pos_e        pos_q, pos_d, cur_pos, next_pos;
  logic        first_q, first_d;
  logic [15:0] crc_q, crc_d, crc_base;
  logic        upd_crc, last, eof;
  logic [7:0]  byte_sel;

  // The first byte of a command is chosen by its kind.
  always_comb begin
    if (first_q) begin
      cur_pos = cmd_i.is_start ? PosDelim : PosData;
    end else begin
      cur_pos = pos_q;
    end
  end

  // The delimiter starts a fresh CRC.
  assign crc_base = (cur_pos == PosDelim) ? CrcInit : crc_q;

  // Byte selection and sequencing per position.
  always_comb begin
    byte_sel = 8'h00;
    next_pos = PosDelim;
    upd_crc  = 1'b1;
    last     = 1'b0;
    eof      = 1'b0;
    case (cur_pos)
      PosDelim: begin
        byte_sel = FrameDelim;
        next_pos = PosDestHi;
      end
      PosDestHi: begin
        byte_sel = cmd_i.dest[15:8];
        next_pos = PosDestLo;
      end
      PosDestLo: begin
        byte_sel = cmd_i.dest[7:0];
        next_pos = PosSrcHi;
      end
      PosSrcHi: begin
        byte_sel = cmd_i.src[15:8];
        next_pos = PosSrcLo;
      end
      PosSrcLo: begin
        byte_sel = cmd_i.src[7:0];
        next_pos = PosLenHi;
      end
      PosLenHi: begin
        byte_sel = cmd_i.len[15:8];
        next_pos = PosLenLo;
      end
      PosLenLo: begin
        byte_sel = cmd_i.len[7:0];
        next_pos = PosCrcHi;
        last     = !cmd_i.close;
      end
      PosData: begin
        byte_sel = cmd_i.data_byte;
        next_pos = PosCrcHi;
        last     = !cmd_i.close;
      end
      PosCrcHi: begin
        byte_sel = crc_q[15:8];
        next_pos = PosCrcLo;
        upd_crc  = 1'b0;
      end
      PosCrcLo: begin
        byte_sel = crc_q[7:0];
        upd_crc  = 1'b0;
        last     = 1'b1;
        eof      = 1'b1;
      end
      default: begin
        upd_crc = 1'b0;
        last    = 1'b1;
      end
    endcase
  end

  assign out_push_o              = !cmd_empty_i && !out_full_i;
  assign cmd_pop_o               = out_push_o && last;
  assign out_item_o.frame_byte   = byte_sel;
  assign out_item_o.end_of_frame = eof;
  assign out_item_o.last_of_run  = last;

  // Advance by one byte per emitted transaction.
  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    crc_d   = crc_q;
    if (out_push_o) begin
      first_d = last;
      pos_d   = next_pos;
      if (upd_crc) begin
        crc_d = crc_add(crc_base, byte_sel);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosDelim;
      first_q <= 1'b1;
      crc_q   <= CrcInit;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
      crc_q   <= crc_d;
    end
  end

endmodule

`default_nettype wire

### sv/crc16_frame_builder.sv
// CRC-16 frame builder.
// Input channel: an item is taken on a rising edge with push high and full low.
// Mode 0 opens a frame and yields the header (0x7E, destination, source,
// length, each high byte first); mode 1 yields one payload byte. The CRC
// (CCITT-FALSE) follows the last payload byte, or the header at once when the
// length is zero. Payload bytes with no frame open give no result.
// Result channel: the oldest result sits on out_data_o while empty is low and
// is taken on a rising edge with pop high.
// Configuration: cfg_ready_o is always high; index 0 length, 1 destination,
// 2 source; other indexes are ignored.
// The byte sequencer emits one result per cycle while a command is queued and
// the result queue has room; a start yields 7 or 9 results and a payload
// byte 1 or 3. Input is taken every cycle while the command queue (CmdDepth
// entries) has room.
// Reset empties both queues, closes any frame and restores register defaults.
// When the receiver stalls, the result queue fills, the sequencer halts, the
// command queue fills and full rises; nothing is lost.
`default_nettype none

module crc16_frame_builder
  import cfb_pkg::*;
#(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_data_i,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  `include "crc16_frame_builder_macros.svh"

  cfg_wr_t   cfg_wr;
  cmd_t      cmd_in, cmd_head;
  logic      cmd_push, cmd_pop, cmd_full, cmd_empty;
  out_item_t out_item, out_head;
  logic      out_push, out_full, out_empty;
  logic [$bits(cmd_t)-1:0]      cmd_rdata;
  logic [$bits(out_item_t)-1:0] out_rdata;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Classifier.
  cfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Command queue between classifier and sequencer.
  cfb_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_rdata);

  // Byte sequencer and CRC.
  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  // Result queue toward the receiver.
  cfb_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_item),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (out_empty)
  );

  assign out_head   = out_item_t'(out_rdata);
  assign out_data_o = out_head;
  assign full       = cmd_full;
  assign empty      = out_empty;

  // Checks on the internal hand-off between the parts.
  `CFB_ASSERT_IMPL(a_push_room, out_push, !out_full, "sequencer pushed into a full result queue")
  `CFB_ASSERT_IMPL(a_pop_on_last, cmd_pop, out_push && out_item.last_of_run, "command retired early")
  `CFB_ASSERT_IMPL(a_eof_last, out_push && out_item.end_of_frame, out_item.last_of_run, "frame end not last")
  `CFB_ASSERT_NEXT(a_start_queued, push && !full && !in_data_i.mode, !cmd_empty, "start item lost")

endmodule

`default_nettype wire

### test/frame_stream_checker.sv
// Shared codes for the frame builder checker and its stimulus.
package cfb_tb_pkg;

  // Input item modes.
  localparam logic ModeStart   = 1'b0;
  localparam logic ModePayload = 1'b1;

  // A register index that maps to no register and must be ignored.
  localparam logic [1:0] CfgIdxUnused = 2'd3;

endpackage

// Watches the input, result and configuration channels, predicts the framed
// byte stream and compares every popped result with the oldest prediction.
module frame_stream_checker
  import cfb_pkg::*;
  import cfb_tb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               full_i,
  input  wire in_item_t           in_data_i,
  input  wire logic               empty_i,
  input  wire logic               pop_i,
  input  wire out_item_t          out_data_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               end_check_i,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Register copies as seen by the framer.
  logic [15:0] len_reg;
  logic [15:0] dest_reg;
  logic [15:0] src_reg;

  // Framing state.
  logic [15:0] crc_acc;
  logic [15:0] bytes_left;
  logic        frame_open;

  // Results of the item being predicted, then the store of expected bytes.
  out_item_t   run_buf [0:8];
  int          run_len;
  out_item_t   frame_bytes_due [$];

  int unsigned fail_tally = 0;
  int unsigned due_count  = 0;
  bit          end_done   = 1'b0;

  assign pending_o    = due_count;
  assign fail_count_o = fail_tally;

  task automatic report_mismatch(input string msg);
    $display("checker @%0t: %s", $time, msg);
    fail_tally++;
  endtask

  // CRC-16/CCITT-FALSE, one bit at a time, MSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    int          i;
    r = acc;
    for (i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  // Appends one byte to the current run, folding it into the CRC if asked.
  task automatic emit_byte(input logic [7:0] b, input logic eof, input bit fold);
    if (fold) begin
      crc_acc = crc_fold(crc_acc, b);
    end
    run_buf[run_len].frame_byte   = b;
    run_buf[run_len].end_of_frame = eof;
    run_buf[run_len].last_of_run  = 1'b0;
    run_len++;
  endtask

  // Emits the CRC high byte first and closes the frame.
  task automatic close_frame();
    logic [15:0] c;
    c = crc_acc;
    emit_byte(c[15:8], 1'b0, 1'b0);
    emit_byte(c[7:0], 1'b1, 1'b0);
    frame_open = 1'b0;
    bytes_left = '0;
    crc_acc    = CrcInit;
  endtask

  // Works out the bytes that one accepted input item causes.
  task automatic predict_frame_bytes(input in_item_t it);
    int k;
    run_len = 0;
    if (it.mode == ModeStart) begin
      crc_acc    = CrcInit;
      frame_open = 1'b1;
      bytes_left = len_reg;
      emit_byte(FrameDelim, 1'b0, 1'b1);
      emit_byte(dest_reg[15:8], 1'b0, 1'b1);
      emit_byte(dest_reg[7:0], 1'b0, 1'b1);
      emit_byte(src_reg[15:8], 1'b0, 1'b1);
      emit_byte(src_reg[7:0], 1'b0, 1'b1);
      emit_byte(len_reg[15:8], 1'b0, 1'b1);
      emit_byte(len_reg[7:0], 1'b0, 1'b1);
      if (bytes_left == 16'd0) begin
        close_frame();
      end
    end else if (frame_open) begin
      emit_byte(it.data_byte, 1'b0, 1'b1);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
        close_frame();
      end
    end
    // Payload with no frame open produces nothing.
    if (run_len > 0) begin
      run_buf[run_len-1].last_of_run = 1'b1;
    end
    for (k = 0; k < run_len; k++) begin
      frame_bytes_due = {frame_bytes_due, run_buf[k]};
    end
  endtask

  // Compares one popped result with the oldest expectation.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frame_bytes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %02h eof %0b last %0b",
                                got.frame_byte, got.end_of_frame, got.last_of_run));
    end else begin
      want = frame_bytes_due.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                  got.frame_byte, want.frame_byte));
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        report_mismatch($sformatf("end_of_frame %0b, expected %0b",
                                  got.end_of_frame, want.end_of_frame));
      end
      if (got.last_of_run !== want.last_of_run) begin
        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                  got.last_of_run, want.last_of_run));
      end
    end
  endtask

  // Results are checked before the same edge's input item and register write
  // are applied, since neither can affect a result already waiting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg    = LenReset;
      dest_reg   = DestReset;
      src_reg    = SrcReset;
      crc_acc    = CrcInit;
      bytes_left = '0;
      frame_open = 1'b0;
      frame_bytes_due.delete();
      due_count  = 0;
    end else begin
      if (pop_i && !empty_i) begin
        check_result(out_data_i);
      end
      if (push_i && !full_i) begin
        predict_frame_bytes(in_data_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgIdxLength: len_reg  = cfg_data_i;
          CfgIdxDest:   dest_reg = cfg_data_i;
          CfgIdxSrc:    src_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (frame_bytes_due.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    frame_bytes_due.size()));
        end
      end
      due_count = frame_bytes_due.size();
    end
  end

endmodule

### test/testbench.sv
// Stimulus and verdict for the CRC-16 frame builder. All checking is done by
// the frame stream checker instantiated beside the block.
module testbench
  import cfb_pkg::*;
  import cfb_tb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 310;
  localparam int IdleCycles  = 12;
  localparam int HoldCycles  = 150;
  localparam int DrainLimit  = 5000;

  typedef enum int {RxFree, RxCoin, RxSparse, RxPairs} rx_style_e;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_item_t           in_data;
  logic               empty;
  logic               pop;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [15:0]        cfg_data;
  logic               end_check;
  int unsigned        pending_count;
  int unsigned        fail_total;

  bit                 hold_req;
  bit                 frame_open;
  logic [15:0]        cur_len;
  int                 burst_left;
  int                 items_done;

  crc16_frame_builder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  frame_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_data_i    (in_data),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .end_check_i  (end_check),
    .pending_o    (pending_count),
    .fail_count_o (fail_total)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  // Offers one item and holds it until the block takes it. Items come in
  // bursts; after each burst push drops for a random gap.
  task automatic send_item(input logic mode, input logic [7:0] b, input bit counted);
    in_item_t it;
    int       gap;
    it.mode      = mode;
    it.data_byte = b;
    @(negedge clk_i);
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    if (counted) begin
      items_done++;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 6);
      @(negedge clk_i);
      push    <= 1'b0;
      in_data <= in_item_t'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Lowers push and waits until every expected result has been popped and
  // the block has had time to finish any item that yields nothing.
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_count != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  // One configuration transaction.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CfgIdxLength) begin
      cur_len = value;
    end
  endtask

  // Start plus the given number of payload bytes.
  task automatic send_frame(input int n_bytes);
    int k;
    send_item(ModeStart, 8'($urandom), 1'b1);
    for (k = 0; k < n_bytes; k++) begin
      send_item(ModePayload, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // One random phase: a fresh setting of the registers, then a run of frames
  // that are mostly complete, with truncated frames and stray bytes mixed in.
  // The phase stops early once enough items have been sent.
  task automatic run_phase(input int frames, input bit squeeze);
    int f;
    int pick;
    int k;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      write_reg(CfgIdxLength, 16'($urandom_range(0, 6)));
    end else if (pick < 9) begin
      write_reg(CfgIdxLength, 16'($urandom_range(7, 24)));
    end else begin
      write_reg(CfgIdxLength, 16'($urandom_range(25, 48)));
    end
    write_reg(CfgIdxDest, 16'($urandom));
    write_reg(CfgIdxSrc, 16'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CfgIdxUnused, 16'($urandom));
    end
    if (squeeze) begin
      hold_req = 1'b1;
    end
    for (f = 0; f < frames; f++) begin
      if (items_done >= RandomItems) begin
        break;
      end
      pick = $urandom_range(0, 19);
      if (pick >= 17 && !frame_open) begin
        // Stray bytes between frames are dropped by the block.
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          send_item(ModePayload, 8'($urandom_range(0, 255)), 1'b0);
        end
        send_frame(int'(cur_len));
        frame_open = 1'b0;
      end else if (pick >= 15 && pick < 17 && cur_len != 16'd0) begin
        // Cut short; the next start abandons it.
        send_frame(int'($urandom_range(0, 32'(cur_len) - 1)));
        frame_open = 1'b1;
      end else begin
        send_frame(int'(cur_len));
        frame_open = 1'b0;
      end
    end
    settle();
  endtask

  // Receiver: pops on a changing pattern, or holds off for a long stretch
  // when the stimulus asks for it so that both queues fill.
  initial begin
    rx_style_e rx_style;
    int        rx_left;
    bit [31:0] rx_tick;
    pop      = 1'b0;
    rx_style = RxFree;
    rx_left  = 0;
    rx_tick  = '0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_style = rx_style_e'($urandom_range(0, 3));
          rx_left  = $urandom_range(20, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_style)
          RxFree:   pop <= 1'b1;
          RxCoin:   pop <= 1'($urandom_range(0, 1));
          RxSparse: pop <= (rx_tick[1:0] == 2'b00);
          default:  pop <= rx_tick[1];
        endcase
      end
    end
  end

  // Main stimulus and verdict.
  initial begin
    int phase;
    rst_ni     = 1'b0;
    push       = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CfgIdxLength;
    cfg_data   = '0;
    end_check  = 1'b0;
    hold_req   = 1'b0;
    frame_open = 1'b0;
    cur_len    = LenReset;
    burst_left = 0;
    items_done = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: a stray byte, then a zero-length frame with the data
    // bits of the start item set.
    send_item(ModePayload, 8'hA5, 1'b0);
    send_item(ModeStart, 8'hFF, 1'b1);
    settle();

    // A one-byte frame, address extremes and an index that maps to nothing.
    write_reg(CfgIdxLength, 16'd1);
    write_reg(CfgIdxDest, 16'hFFFF);
    write_reg(CfgIdxSrc, 16'h0000);
    write_reg(CfgIdxUnused, 16'hBEEF);
    send_item(ModeStart, 8'h00, 1'b1);
    send_item(ModePayload, 8'h00, 1'b1);
    send_item(ModePayload, 8'hFF, 1'b0);
    settle();

    // A start inside an open frame abandons it.
    write_reg(CfgIdxLength, 16'd3);
    send_item(ModeStart, 8'h00, 1'b1);
    send_item(ModePayload, 8'hFF, 1'b1);
    send_item(ModeStart, 8'h00, 1'b1);
    send_item(ModePayload, 8'h00, 1'b1);
    send_item(ModePayload, 8'h80, 1'b1);
    send_item(ModePayload, 8'h7F, 1'b1);
    settle();

    // Registers written mid-frame only apply to the next frame.
    write_reg(CfgIdxLength, 16'd2);
    send_item(ModeStart, 8'h00, 1'b1);
    send_item(ModePayload, 8'h01, 1'b1);
    settle();
    write_reg(CfgIdxLength, 16'd0);
    write_reg(CfgIdxDest, 16'h0000);
    send_item(ModePayload, 8'hFE, 1'b1);
    send_item(ModeStart, 8'h00, 1'b1);
    settle();

    // Largest length: the header and two payload bytes, the frame is left open.
    write_reg(CfgIdxLength, 16'hFFFF);
    write_reg(CfgIdxSrc, 16'hFFFF);
    write_reg(CfgIdxUnused, 16'hFFFF);
    send_item(ModeStart, 8'h00, 1'b1);
    send_item(ModePayload, 8'h55, 1'b1);
    send_item(ModePayload, 8'hAA, 1'b1);
    settle();
    frame_open = 1'b1;

    // Random phases.
    items_done = 0;
    phase      = 0;
    while (items_done < RandomItems) begin
      run_phase($urandom_range(6, 10), (phase == 0) || (phase == 3));
      phase++;
    end

    settle();
    @(negedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(negedge clk_i);
    if (fail_total == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
